/* hw/rtl/kas_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// kas_pkg
// Shared types, constants and helpers for the keyword affine substitution
// cipher: the two character sets, command and register codes, table access
// requests and small modulo-37 helpers.
// ---------------------------------------------------------------------------
package kas_pkg;

  localparam int ALPHABET_SIZE = 37;
  localparam int TBL_DEPTH     = 2 * ALPHABET_SIZE;

  typedef logic [5:0] pos_t;
  typedef logic [6:0] addr_t;
  typedef logic [7:0] byte_t;

  // Command codes of an input request
  typedef enum logic [1:0] {
    CMD_KEY  = 2'd0,
    CMD_SEAL = 2'd1,
    CMD_DATA = 2'd2
  } cmd_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_MULT      = 3'd0,
    REG_SHIFT     = 3'd1,
    REG_KEY_START = 3'd2,
    REG_DECRYPT   = 3'd3,
    REG_KEEP_NL   = 3'd4
  } reg_idx_t;

  localparam byte_t NEWLINE = 8'h0A;

  // Lower set: a..n, n-tilde, o..z, space, underscore, o-acute, e-acute, 0..5
  localparam byte_t LOWER_SET [ALPHABET_SIZE] = '{
    8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69, 8'h6A,
    8'h6B, 8'h6C, 8'h6D, 8'h6E, 8'hF1, 8'h6F, 8'h70, 8'h71, 8'h72, 8'h73,
    8'h74, 8'h75, 8'h76, 8'h77, 8'h78, 8'h79, 8'h7A, 8'h20, 8'h5F, 8'hF3,
    8'hE9, 8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35
  };

  // Upper set: A..N, N-tilde, O..Z, i-acute, u-acute, a-acute, @, 6..9, '.', ','
  localparam byte_t UPPER_SET [ALPHABET_SIZE] = '{
    8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4A,
    8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'hD1, 8'h4F, 8'h50, 8'h51, 8'h52, 8'h53,
    8'h54, 8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5A, 8'hED, 8'hFA, 8'hE1,
    8'h40, 8'h36, 8'h37, 8'h38, 8'h39, 8'h2E, 8'h2C
  };

  typedef struct packed {
    pos_t mult;
    pos_t shift;
    pos_t key_start;
    logic decrypt;
    logic keep_newline;
  } cfg_t;

  typedef struct packed {
    logic lo;
    logic up;
    pos_t pos;
  } char_hit_t;

  // Write and read request from the sequencer to the table memories
  typedef struct packed {
    logic  fwd_we;
    addr_t fwd_addr;
    pos_t  fwd_data;
    logic  inv_we;
    addr_t inv_addr;
    pos_t  inv_data;
    logic  rd_en;
    addr_t rd_addr;
  } tbl_req_t;

  typedef struct packed {
    logic  valid;
    byte_t ch;
  } res_t;

  // Reduce a 6-bit value modulo 37
  function automatic pos_t mod37(input pos_t x);
    if (x >= 6'(ALPHABET_SIZE)) begin
      return x - 6'(ALPHABET_SIZE);
    end
    return x;
  endfunction

  // Sum of two values below 37, modulo 37
  function automatic pos_t add_mod37(input pos_t a, input pos_t b);
    logic [6:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 7'(ALPHABET_SIZE)) begin
      s = s - 7'(ALPHABET_SIZE);
    end
    return s[5:0];
  endfunction

  // Locate a byte in either set
  function automatic char_hit_t find_char(input byte_t c);
    char_hit_t h;
    h = '0;
    for (int i = 0; i < ALPHABET_SIZE; i++) begin
      if (LOWER_SET[i] == c) begin
        h.lo  = 1'b1;
        h.pos = 6'(i);
      end
    end
    for (int i = 0; i < ALPHABET_SIZE; i++) begin
      if (UPPER_SET[i] == c) begin
        h.up  = 1'b1;
        h.pos = 6'(i);
      end
    end
    return h;
  endfunction

  // Byte at a position of the chosen set
  function automatic byte_t char_at(input logic up, input pos_t r);
    pos_t rr;
    rr = mod37(r);
    return up ? UPPER_SET[rr] : LOWER_SET[rr];
  endfunction

  // Table address: lower set in the first 37 entries, upper set after it
  function automatic addr_t tbl_addr(input logic up, input pos_t p);
    return up ? (7'(p) + 7'(ALPHABET_SIZE)) : 7'(p);
  endfunction

  // Position within its set for a table address
  function automatic pos_t addr_pos(input addr_t a);
    if (a >= 7'(ALPHABET_SIZE)) begin
      return 6'(a - 7'(ALPHABET_SIZE));
    end
    return a[5:0];
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/kas_tables.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// kas_tables
// Forward and inverse substitution memories, one entry per symbol of both
// sets. One write port per memory, one shared read address, registered
// read data. Entries not yet written read as the identity order.
// ---------------------------------------------------------------------------
module kas_tables
  import kas_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire tbl_req_t req,
  output pos_t          fwd_q,
  output pos_t          inv_q
);

  pos_t fwd_mem [TBL_DEPTH];
  pos_t inv_mem [TBL_DEPTH];
  logic [TBL_DEPTH-1:0] fwd_written;
  logic [TBL_DEPTH-1:0] inv_written;

  // Track written entries; reset restores the identity order
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_written <= '0;
      inv_written <= '0;
    end else begin
      if (req.fwd_we) begin
        fwd_written[req.fwd_addr] <= 1'b1;
      end
      if (req.inv_we) begin
        inv_written[req.inv_addr] <= 1'b1;
      end
    end
  end

  // Write the memories
  always_ff @(posedge clk) begin
    if (req.fwd_we) begin
      fwd_mem[req.fwd_addr] <= req.fwd_data;
    end
    if (req.inv_we) begin
      inv_mem[req.inv_addr] <= req.inv_data;
    end
  end

  // Registered read; hold the last data between reads
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      fwd_q <= fwd_written[req.rd_addr] ? fwd_mem[req.rd_addr] : addr_pos(req.rd_addr);
      inv_q <= inv_written[req.rd_addr] ? inv_mem[req.rd_addr] : addr_pos(req.rd_addr);
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/kas_ctrl.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// kas_ctrl
// Request sequencer: places keyword letters, walks the affine order to seal
// both tables, and issues table lookups for data characters.
// ---------------------------------------------------------------------------
module kas_ctrl
  import kas_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] cmd,
  input  wire byte_t      in_char,
  input  wire cfg_t       cfg,
  input  wire pos_t       fwd_q,
  input  wire pos_t       inv_q,
  input  wire logic       res_take,
  output tbl_req_t        req,
  output res_t            res
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOOK = 3'b010,
    ST_SEAL = 3'b100
  } state_t;

  state_t state, state_next;

  logic sealed, sealed_next;
  logic [ALPHABET_SIZE-1:0] lower_present, lower_present_next;
  logic [ALPHABET_SIZE-1:0] upper_present, upper_present_next;
  pos_t lower_slot, lower_slot_next;
  pos_t upper_slot, upper_slot_next;
  logic lower_keyed, lower_keyed_next;
  logic upper_keyed, upper_keyed_next;

  pos_t seal_j, seal_j_next;
  logic seal_up, seal_up_next;
  pos_t seal_v, seal_v_next;
  pos_t seal_slot, seal_slot_next;
  logic look_up, look_up_next;
  logic look_nl, look_nl_next;

  logic      acc;
  char_hit_t hit;
  pos_t      ks, mm, ss;
  logic [ALPHABET_SIZE-1:0] lo_pres_eff, up_pres_eff, cur_present;
  pos_t      lo_slot_eff, up_slot_eff;
  logic      cur_keyed;
  pos_t      rd_pos;

  assign in_ready = (state == ST_IDLE);
  assign acc      = in_valid && in_ready;
  assign hit      = find_char(in_char);
  assign ks       = mod37(cfg.key_start);
  assign ss       = mod37(cfg.shift);

  // Multiplier of zero modulo 37 acts as one
  always_comb begin
    mm = mod37(cfg.mult);
    if (mm == '0) begin
      mm = 6'd1;
    end
  end

  // A keyword request while sealed starts a fresh keying pass
  assign lo_pres_eff = sealed ? '0 : lower_present;
  assign up_pres_eff = sealed ? '0 : upper_present;
  assign lo_slot_eff = sealed ? ks : lower_slot;
  assign up_slot_eff = sealed ? ks : upper_slot;

  assign cur_keyed   = seal_up ? upper_keyed : lower_keyed;
  assign cur_present = seal_up ? upper_present : lower_present;
  assign rd_pos      = cfg.decrypt ? inv_q : fwd_q;

  // Next state, table requests and result
  always_comb begin
    state_next         = state;
    sealed_next        = sealed;
    lower_present_next = lower_present;
    upper_present_next = upper_present;
    lower_slot_next    = lower_slot;
    upper_slot_next    = upper_slot;
    lower_keyed_next   = lower_keyed;
    upper_keyed_next   = upper_keyed;
    seal_j_next        = seal_j;
    seal_up_next       = seal_up;
    seal_v_next        = seal_v;
    seal_slot_next     = seal_slot;
    look_up_next       = look_up;
    look_nl_next       = look_nl;
    req                = '0;
    res                = '0;

    case (state)
      ST_IDLE: begin
        if (acc && (cmd == CMD_KEY)) begin
          if (sealed) begin
            lower_present_next = '0;
            upper_present_next = '0;
            lower_keyed_next   = 1'b0;
            upper_keyed_next   = 1'b0;
            lower_slot_next    = ks;
            upper_slot_next    = ks;
            sealed_next        = 1'b0;
          end
          // Place a new keyword letter, skip a repeat
          if (hit.lo) begin
            if (!lo_pres_eff[hit.pos]) begin
              req.fwd_we         = 1'b1;
              req.fwd_addr       = tbl_addr(1'b0, lo_slot_eff);
              req.fwd_data       = hit.pos;
              req.inv_we         = 1'b1;
              req.inv_addr       = tbl_addr(1'b0, hit.pos);
              req.inv_data       = lo_slot_eff;
              lower_present_next = lo_pres_eff | (ALPHABET_SIZE'(1) << hit.pos);
              lower_slot_next    = add_mod37(lo_slot_eff, 6'd1);
              lower_keyed_next   = 1'b1;
            end
          end else if (hit.up) begin
            if (!up_pres_eff[hit.pos]) begin
              req.fwd_we         = 1'b1;
              req.fwd_addr       = tbl_addr(1'b1, up_slot_eff);
              req.fwd_data       = hit.pos;
              req.inv_we         = 1'b1;
              req.inv_addr       = tbl_addr(1'b1, hit.pos);
              req.inv_data       = up_slot_eff;
              upper_present_next = up_pres_eff | (ALPHABET_SIZE'(1) << hit.pos);
              upper_slot_next    = add_mod37(up_slot_eff, 6'd1);
              upper_keyed_next   = 1'b1;
            end
          end
        end else if (acc && (cmd == CMD_SEAL)) begin
          state_next     = ST_SEAL;
          seal_j_next    = '0;
          seal_up_next   = 1'b0;
          seal_v_next    = ss;
          seal_slot_next = lower_slot;
        end else if (acc && (cmd == CMD_DATA) && sealed) begin
          if (hit.lo || hit.up) begin
            req.rd_en    = 1'b1;
            req.rd_addr  = tbl_addr(hit.up, hit.pos);
            look_up_next = hit.up;
            look_nl_next = 1'b0;
            state_next   = ST_LOOK;
          end else if ((in_char == NEWLINE) && cfg.keep_newline) begin
            look_nl_next = 1'b1;
            state_next   = ST_LOOK;
          end
        end
      end

      ST_LOOK: begin
        // Offer the substituted byte; hold until the output stage takes it
        res.valid = 1'b1;
        res.ch    = look_nl ? NEWLINE : char_at(look_up, rd_pos);
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end

      ST_SEAL: begin
        // One step of the affine walk per cycle
        if (!cur_keyed) begin
          req.fwd_we   = 1'b1;
          req.fwd_addr = tbl_addr(seal_up, seal_j);
          req.fwd_data = seal_v;
          req.inv_we   = 1'b1;
          req.inv_addr = tbl_addr(seal_up, seal_v);
          req.inv_data = seal_j;
        end else if (!cur_present[seal_v]) begin
          req.fwd_we     = 1'b1;
          req.fwd_addr   = tbl_addr(seal_up, seal_slot);
          req.fwd_data   = seal_v;
          req.inv_we     = 1'b1;
          req.inv_addr   = tbl_addr(seal_up, seal_v);
          req.inv_data   = seal_slot;
          seal_slot_next = add_mod37(seal_slot, 6'd1);
        end
        seal_v_next = add_mod37(seal_v, mm);
        seal_j_next = seal_j + 6'd1;
        if (seal_j == 6'(ALPHABET_SIZE - 1)) begin
          if (!seal_up) begin
            seal_up_next   = 1'b1;
            seal_j_next    = '0;
            seal_v_next    = ss;
            seal_slot_next = upper_slot;
          end else begin
            state_next         = ST_IDLE;
            sealed_next        = 1'b1;
            lower_present_next = '0;
            upper_present_next = '0;
            lower_keyed_next   = 1'b0;
            upper_keyed_next   = 1'b0;
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      sealed        <= 1'b1;
      lower_present <= '0;
      upper_present <= '0;
      lower_slot    <= '0;
      upper_slot    <= '0;
      lower_keyed   <= 1'b0;
      upper_keyed   <= 1'b0;
      seal_j        <= '0;
      seal_up       <= 1'b0;
    end else begin
      state         <= state_next;
      sealed        <= sealed_next;
      lower_present <= lower_present_next;
      upper_present <= upper_present_next;
      lower_slot    <= lower_slot_next;
      upper_slot    <= upper_slot_next;
      lower_keyed   <= lower_keyed_next;
      upper_keyed   <= upper_keyed_next;
      seal_j        <= seal_j_next;
      seal_up       <= seal_up_next;
    end
  end

  // Working registers of the walk and the lookup
  always_ff @(posedge clk) begin
    seal_v    <= seal_v_next;
    seal_slot <= seal_slot_next;
    look_up   <= look_up_next;
    look_nl   <= look_nl_next;
  end

endmodule
`default_nettype wire

/* hw/rtl/keyword_affine_substitution_cipher.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// keyword_affine_substitution_cipher
// Keyword affine substitution over two 37-symbol byte sets.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, cmd, in_char) takes one request at a
//   time. A keyword request leaves in_ready high; a data request passes a
//   table read, then its result goes into the output register; a seal request
//   walks the affine order once per set, one table entry per cycle, and holds
//   in_ready low from its acceptance until the walk is done. The walk through
//   the single write port of each table memory sets the seal time.
//   Output channel (out_valid/out_ready, out_char) is a registered stage: a
//   data result moves from the lookup step into the output register. While
//   the receiver stalls, a further request is still taken; a second data
//   result waits in the lookup step until the output register frees.
//   Configuration: cfg_we writes cfg_data to register cfg_index at once;
//   write only while no request is in flight.
//   Reset clears all control state, restores register defaults and leaves
//   both tables in the identity order, sealed; no clearing pass is needed.
// ---------------------------------------------------------------------------
module keyword_affine_substitution_cipher
  import kas_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] cmd,
  input  wire logic [7:0] in_char,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_char,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [5:0] cfg_data
);

  cfg_t     cfg;
  tbl_req_t req;
  res_t     res;
  pos_t     fwd_q;
  pos_t     inv_q;
  logic     res_take;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mult         <= 6'd1;
      cfg.shift        <= '0;
      cfg.key_start    <= '0;
      cfg.decrypt      <= 1'b0;
      cfg.keep_newline <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MULT:      cfg.mult         <= cfg_data;
        REG_SHIFT:     cfg.shift        <= cfg_data;
        REG_KEY_START: cfg.key_start    <= cfg_data;
        REG_DECRYPT:   cfg.decrypt      <= cfg_data[0];
        REG_KEEP_NL:   cfg.keep_newline <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  kas_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .in_char  (in_char),
    .cfg      (cfg),
    .fwd_q    (fwd_q),
    .inv_q    (inv_q),
    .res_take (res_take),
    .req      (req),
    .res      (res)
  );

  kas_tables u_tables (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .fwd_q (fwd_q),
    .inv_q (inv_q)
  );

  // Output register: load when empty or being drained
  assign res_take = res.valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_char <= res.ch;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/kas_checker.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// kas_checker
// Port-level checks of the cipher block, bound to the top level.
// ---------------------------------------------------------------------------
module kas_checker
  import kas_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [1:0] cmd,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_char
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_char))
    else $error("stalled result changed or vanished");

  // A seal request occupies the block after acceptance
  a_seal_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (cmd == CMD_SEAL) |=> !in_ready)
    else $error("request taken during seal walk");

  // A keyword request does not block the input
  a_key_fast: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (cmd == CMD_KEY) |=> in_ready)
    else $error("keyword request blocked the input");

  // A fresh result follows a data request that passed the table read and the lookup step
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && (cmd == CMD_DATA), 2))
    else $error("result without a data request");

endmodule

bind keyword_affine_substitution_cipher kas_checker u_kas_checker (.*);
`default_nettype wire

/* bench/kas_cipher_checker.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// kas_cipher_checker
// Watches the request, result and register ports of the keyword affine
// substitution cipher, keeps its own copy of the substitution tables and
// registers, predicts each substituted character and compares it with what
// the block returns, oldest first.
// ---------------------------------------------------------------------------
module kas_cipher_checker
  import kas_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [1:0] cmd,
  input  logic [7:0] in_char,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_char,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [5:0] cfg_data,
  output int         fail_count,
  output int         pending,
  output int         checked
);

  localparam int SET_LOWER = 0;
  localparam int SET_UPPER = 1;

  // Predicted tables, one row per character set
  pos_t                     fwd_tbl   [2][ALPHABET_SIZE];
  pos_t                     inv_tbl   [2][ALPHABET_SIZE];
  logic [ALPHABET_SIZE-1:0] placed    [2];
  int                       next_slot [2];
  logic                     keyed     [2];
  logic                     sealed;

  // Register copies
  pos_t cur_mult;
  pos_t cur_shift;
  pos_t cur_key_start;
  logic cur_decrypt;
  logic cur_keep_nl;

  byte_t expected_chars [$];
  byte_t want;
  int    errors    = 0;
  int    n_checked = 0;

  // Position of a byte within one set, or ALPHABET_SIZE when absent
  function automatic int set_position(input int set_sel, input byte_t ch);
    for (int i = 0; i < ALPHABET_SIZE; i++) begin
      if ((set_sel == SET_UPPER ? UPPER_SET[i] : LOWER_SET[i]) == ch) begin
        return i;
      end
    end
    return ALPHABET_SIZE;
  endfunction

  task automatic reset_model();
    for (int s = 0; s < 2; s++) begin
      for (int i = 0; i < ALPHABET_SIZE; i++) begin
        fwd_tbl[s][i] = pos_t'(i);
        inv_tbl[s][i] = pos_t'(i);
      end
      placed[s]    = '0;
      next_slot[s] = 0;
      keyed[s]     = 1'b0;
    end
    sealed        = 1'b1;
    cur_mult      = 6'd1;
    cur_shift     = 6'd0;
    cur_key_start = 6'd0;
    cur_decrypt   = 1'b0;
    cur_keep_nl   = 1'b0;
    expected_chars.delete();
  endtask

  // Drop a keyword letter into the next free slot unless already placed
  task automatic place_letter(input int s, input int p);
    if (!placed[s][p]) begin
      fwd_tbl[s][next_slot[s]] = pos_t'(p);
      placed[s][p] = 1'b1;
      next_slot[s] = (next_slot[s] + 1) % ALPHABET_SIZE;
      keyed[s]     = 1'b1;
    end
  endtask

  // Fill the free slots in affine order, then rebuild the inverse
  task automatic build_table(input int s);
    int m;
    int sh;
    int slot;
    int v;
    m = int'(cur_mult) % ALPHABET_SIZE;
    if (m == 0) begin
      m = 1;
    end
    sh   = int'(cur_shift) % ALPHABET_SIZE;
    slot = next_slot[s];
    for (int j = 0; j < ALPHABET_SIZE; j++) begin
      v = (j * m + sh) % ALPHABET_SIZE;
      if (!keyed[s]) begin
        fwd_tbl[s][j] = pos_t'(v);
      end else if (!placed[s][v]) begin
        fwd_tbl[s][slot] = pos_t'(v);
        slot = (slot + 1) % ALPHABET_SIZE;
      end
    end
    for (int j = 0; j < ALPHABET_SIZE; j++) begin
      inv_tbl[s][fwd_tbl[s][j]] = pos_t'(j);
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [5:0] data);
    case (idx)
      REG_MULT:      cur_mult      = data;
      REG_SHIFT:     cur_shift     = data;
      REG_KEY_START: cur_key_start = data;
      REG_DECRYPT:   cur_decrypt   = data[0];
      REG_KEEP_NL:   cur_keep_nl   = data[0];
      default: ;
    endcase
  endtask

  // Advance the predicted cipher by one request, queueing any result
  task automatic advance_cipher(input logic [1:0] op, input byte_t ch);
    int lp;
    int up;
    int r;
    lp = set_position(SET_LOWER, ch);
    up = set_position(SET_UPPER, ch);
    case (op)
      CMD_KEY: begin
        if (sealed) begin
          for (int s = 0; s < 2; s++) begin
            placed[s]    = '0;
            keyed[s]     = 1'b0;
            next_slot[s] = int'(cur_key_start) % ALPHABET_SIZE;
          end
          sealed = 1'b0;
        end
        if (lp < ALPHABET_SIZE) begin
          place_letter(SET_LOWER, lp);
        end else if (up < ALPHABET_SIZE) begin
          place_letter(SET_UPPER, up);
        end
      end
      CMD_SEAL: begin
        build_table(SET_LOWER);
        build_table(SET_UPPER);
        for (int s = 0; s < 2; s++) begin
          placed[s] = '0;
          keyed[s]  = 1'b0;
        end
        sealed = 1'b1;
      end
      CMD_DATA: begin
        if (sealed) begin
          if (lp < ALPHABET_SIZE) begin
            r = cur_decrypt ? inv_tbl[SET_LOWER][lp] : fwd_tbl[SET_LOWER][lp];
            expected_chars.push_back(LOWER_SET[r]);
          end else if (up < ALPHABET_SIZE) begin
            r = cur_decrypt ? inv_tbl[SET_UPPER][up] : fwd_tbl[SET_UPPER][up];
            expected_chars.push_back(UPPER_SET[r]);
          end else if (ch == NEWLINE && cur_keep_nl) begin
            expected_chars.push_back(NEWLINE);
          end
        end
      end
      default: ;
    endcase
  endtask

  // Compare results, then apply register writes and requests of this edge
  always @(posedge clk) begin
    if (rst) begin
      reset_model();
    end else begin
      if (out_valid === 1'b1 && out_ready) begin
        if (expected_chars.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got %02h", $time, out_char);
        end else begin
          want = expected_chars.pop_front();
          n_checked++;
          if (out_char !== want) begin
            errors++;
            $display("%0t: out_char mismatch, expected %02h, got %02h",
                     $time, want, out_char);
          end
        end
      end
      if (cfg_we) begin
        write_reg(cfg_index, cfg_data);
      end
      if (in_valid && in_ready === 1'b1) begin
        advance_cipher(cmd, in_char);
      end
    end
    fail_count <= errors;
    pending    <= expected_chars.size();
    checked    <= n_checked;
  end

endmodule

/* bench/tb_keyword_affine_substitution_cipher.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_keyword_affine_substitution_cipher
// Drives keyword, seal and data requests into the cipher under a range of
// multiplier, shift, key offset and mode settings, with random gaps on both
// channels; a side checker predicts and compares every substituted byte.
// ---------------------------------------------------------------------------
module tb_keyword_affine_substitution_cipher
  import kas_pkg::*;
;

  localparam logic [1:0] CMD_UNUSED    = 2'd3;
  localparam int         RANDOM_ITEMS  = 1600;
  localparam int         SETTLE_CYCLES = 100;
  localparam int         IDLE_LIMIT    = 2000;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic [1:0] cmd       = '0;
  logic [7:0] in_char   = '0;
  logic       out_ready = 1'b0;
  logic       cfg_we    = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [5:0] cfg_data  = '0;
  wire        in_ready;
  wire        out_valid;
  wire  [7:0] out_char;

  int fail_count;
  int pending;
  int checked;

  int items_sent = 0;
  int n_key      = 0;
  int n_seal     = 0;
  int n_data     = 0;
  int n_other    = 0;
  int n_phases   = 0;
  int tx_mode    = 1;
  int rx_mode    = 1;
  int idle_count = 0;

  pos_t cur_mult;
  pos_t cur_shift;
  pos_t cur_key_start;
  logic cur_decrypt;
  logic cur_keep_nl;

  keyword_affine_substitution_cipher dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .in_char   (in_char),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  kas_cipher_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .in_char    (in_char),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_char   (out_char),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Gap before an item: none, uniform, or mostly back to back
  function automatic int draw_gap(input int mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, 15);
      default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 15) : 0;
    endcase
  endfunction

  // Register value biased towards the edges and out-of-range values
  function automatic pos_t draw_reg(input int lo, input int hi);
    case ($urandom_range(0, 9))
      0:       return 6'(lo);
      1:       return 6'(hi);
      2:       return 6'($urandom_range(37, 63));
      3:       return 6'd0;
      default: return 6'($urandom_range(lo, hi));
    endcase
  endfunction

  function automatic byte_t pick_letter();
    if ($urandom_range(0, 1) == 0) begin
      return LOWER_SET[$urandom_range(0, ALPHABET_SIZE - 1)];
    end
    return UPPER_SET[$urandom_range(0, ALPHABET_SIZE - 1)];
  endfunction

  function automatic byte_t pick_data();
    case ($urandom_range(0, 19))
      0:       return NEWLINE;
      1, 2:    return 8'($urandom_range(0, 255));
      default: return pick_letter();
    endcase
  endfunction

  // Present one request and hold it until the block takes it
  task automatic send_req(input logic [1:0] op, input byte_t ch);
    int gap;
    gap = draw_gap(tx_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= op;
    in_char  <= ch;
    do @(posedge clk); while (in_ready !== 1'b1);
    items_sent++;
    case (op)
      CMD_KEY:  n_key++;
      CMD_SEAL: n_seal++;
      CMD_DATA: n_data++;
      default:  n_other++;
    endcase
  endtask

  task automatic key_run(input int n);
    repeat (n) begin
      send_req(CMD_KEY, ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                    : pick_letter());
    end
  endtask

  task automatic data_run(input int n);
    repeat (n) send_req(CMD_DATA, pick_data());
  endtask

  // Drop valid, drain the outstanding results and let a seal walk finish
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all five registers back to back; call only while idle
  task automatic apply_cfg(input pos_t m, input pos_t s, input pos_t k,
                           input logic d, input logic nl);
    cur_mult      = m;
    cur_shift     = s;
    cur_key_start = k;
    cur_decrypt   = d;
    cur_keep_nl   = nl;
    cfg_we    <= 1'b1;
    cfg_index <= REG_MULT;
    cfg_data  <= m;
    @(posedge clk);
    cfg_index <= REG_SHIFT;
    cfg_data  <= s;
    @(posedge clk);
    cfg_index <= REG_KEY_START;
    cfg_data  <= k;
    @(posedge clk);
    cfg_index <= REG_DECRYPT;
    cfg_data  <= {5'd0, d};
    @(posedge clk);
    cfg_index <= REG_KEEP_NL;
    cfg_data  <= {5'd0, nl};
    @(posedge clk);
    cfg_we    <= 1'b0;
    n_phases++;
  endtask

  // Receiver: stall for a drawn number of cycles, then take one result
  initial begin
    int n;
    forever begin
      n = draw_gap(rx_mode);
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid === 1'b1 && out_ready));
    end
  end

  // Watchdog: end the run once nothing has moved for too long
  initial begin
    while (idle_count < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
        idle_count = 0;
      end else begin
        idle_count++;
      end
    end
    $display("%0t: no request or result accepted for %0d cycles", $time, IDLE_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int base;
    int kind;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset tables: identity, sealed, newline dropped
    send_req(CMD_DATA, 8'h61);
    send_req(CMD_DATA, 8'h2C);
    send_req(CMD_DATA, NEWLINE);
    send_req(CMD_DATA, 8'hFF);
    send_req(CMD_UNUSED, 8'hFF);
    send_req(CMD_SEAL, 8'h00);
    settle();

    // Largest in-range settings, newline passed through, keying with wrap
    apply_cfg(6'd36, 6'd36, 6'd36, 1'b0, 1'b1);
    send_req(CMD_DATA, NEWLINE);
    send_req(CMD_SEAL, 8'h00);
    send_req(CMD_DATA, 8'h20);
    send_req(CMD_KEY, 8'h00);
    send_req(CMD_KEY, 8'h7A);
    send_req(CMD_KEY, 8'h7A);
    send_req(CMD_KEY, 8'h51);
    send_req(CMD_DATA, 8'h61);
    send_req(CMD_KEY, 8'hE9);
    send_req(CMD_SEAL, 8'h00);
    send_req(CMD_DATA, 8'h7A);
    send_req(CMD_DATA, 8'h51);
    send_req(CMD_DATA, 8'h35);
    send_req(CMD_DATA, 8'h61);
    settle();

    // Out-of-range registers, decrypt, only the upper set keyed
    apply_cfg(6'd63, 6'd63, 6'd63, 1'b1, 1'b0);
    send_req(CMD_KEY, 8'h41);
    send_req(CMD_SEAL, 8'h00);
    send_req(CMD_DATA, 8'h41);
    send_req(CMD_DATA, 8'hF1);
    send_req(CMD_DATA, NEWLINE);
    settle();

    // Multiplier of zero modulo 37 behaves as one
    apply_cfg(6'd37, 6'd0, 6'd0, 1'b0, 1'b0);
    send_req(CMD_SEAL, 8'h00);
    send_req(CMD_DATA, 8'h2E);
    settle();

    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      tx_mode = $urandom_range(0, 2);
      rx_mode = $urandom_range(0, 2);
      apply_cfg(draw_reg(1, 36), draw_reg(0, 36), draw_reg(0, 36),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        // Well-formed: keyword, seal, then data both ways through the tables
        key_run(($urandom_range(0, 5) == 0) ? $urandom_range(20, 45)
                                            : $urandom_range(0, 12));
        send_req(CMD_SEAL, 8'($urandom_range(0, 255)));
        data_run($urandom_range(8, 30));
        settle();
        apply_cfg(cur_mult, cur_shift, cur_key_start, ~cur_decrypt, cur_keep_nl);
        data_run($urandom_range(8, 30));
      end else if (kind == 7) begin
        // Purely affine tables
        send_req(CMD_SEAL, 8'($urandom_range(0, 255)));
        data_run($urandom_range(8, 30));
      end else if (kind == 8) begin
        // Broken: data while keying, sometimes never sealed
        key_run($urandom_range(1, 6));
        data_run($urandom_range(2, 5));
        send_req(CMD_UNUSED, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1) == 1) begin
          send_req(CMD_SEAL, 8'($urandom_range(0, 255)));
          data_run($urandom_range(5, 15));
        end
      end else begin
        // Noise: any command with any byte
        repeat ($urandom_range(6, 14)) begin
          send_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end
        send_req(CMD_SEAL, 8'($urandom_range(0, 255)));
        data_run($urandom_range(5, 15));
      end
      settle();
    end

    $display("Covered %0d keyword, %0d seal, %0d data and %0d unused-command requests",
             n_key, n_seal, n_data, n_other);
    $display("over %0d register settings; %0d substituted characters compared",
             n_phases, checked);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/kas_pkg.sv
hw/rtl/kas_tables.sv
hw/rtl/kas_ctrl.sv
hw/rtl/keyword_affine_substitution_cipher.sv
hw/rtl/kas_checker.sv
bench/kas_cipher_checker.sv
bench/tb_keyword_affine_substitution_cipher.sv
